FILE: src/dbbe_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the dual band bass exciter.
// Used by every module of the block; depends on nothing.
package dbbe_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int CHANNELS_DEF     = 2;

  localparam int SIG_W     = 32;
  localparam int COEF_W    = 20;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 24;
  localparam int ACC_W     = 64;
  localparam int OACC_W    = 40;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 60;
  localparam int GAIN_W    = 32;

  localparam logic signed [MUL_B_W-1:0] DC_RATE = 24'sd2147484;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B1_LP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1_BP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B1_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B2_LP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B2_BP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B2_GAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_B2_EN   = 3'd6;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd2048;

  typedef struct packed {
    logic vld;
    logic clr;
    logic neg;
    logic dbl;
  } mac_op_t;

  // per channel, per band filter and tracking state
  typedef struct packed {
    logic [3:0][SIG_W-1:0] lp;
    logic [3:0][SIG_W-1:0] bp;
    logic [SIG_W-1:0]      dc;
  } slot_t;

  function automatic logic signed [SIG_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[SIG_W-1:0];
    end
  endfunction

endpackage

FILE: src/dbbe_mac.sv
`timescale 1ns / 1ps
// Shared two stage multiply-accumulate unit: registered product, then accumulate.
// Depends on dbbe_pkg.
module dbbe_mac (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  dbbe_pkg::mac_op_t                        op_i,
  input  logic signed [dbbe_pkg::MUL_A_W-1:0]      a_i,
  input  logic signed [dbbe_pkg::MUL_B_W-1:0]      b_i,
  output logic signed [dbbe_pkg::ACC_W-1:0]        acc_o
);
  import dbbe_pkg::*;

  localparam int PROD_W = MUL_A_W + MUL_B_W;

  logic signed [PROD_W-1:0] prod_q;
  mac_op_t                  op_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  term;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  always_comb begin
    term = ACC_W'(prod_q);
    if (op_q.dbl) begin
      term = term <<< 1;
    end
    if (op_q.neg) begin
      term = -term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= '0;
      acc_q <= '0;
    end else begin
      op_q <= op_i;
      if (op_q.vld) begin
        acc_q <= (op_q.clr ? '0 : acc_q) + term;
      end
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: src/dbbe_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider for the soft clip: round(mag * 2^(QW-1) / (2^(QW-1) + mag)).
// One quotient bit per cycle. Depends on dbbe_pkg.
module dbbe_div #(
  parameter int QW = dbbe_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dbbe_pkg::SIG_W-1:0] mag_i,
  output logic                       busy_o,
  output logic [QW-1:0]              quo_o
);
  import dbbe_pkg::*;

  localparam int FRAC  = QW - 1;
  localparam int DEN_W = SIG_W + 1;
  localparam int REM_W = SIG_W + 2;
  localparam int CNT_W = $clog2(QW + 1);

  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] den_q;
  logic [ACC_W-1:0] num;
  logic [REM_W-1:0] rem_q;
  logic [QW-1:0]    low_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [REM_W:0]   trial;
  logic             fits;

  assign den = (DEN_W'(1) << FRAC) + DEN_W'(mag_i);
  // rounding: add half the divisor to the numerator
  assign num = (ACC_W'(mag_i) << FRAC) + ACC_W'(den >> 1);

  assign trial = {rem_q, low_q[QW-1]};
  assign fits  = trial >= (REM_W + 1)'(den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den;
      rem_q <= REM_W'(num >> QW);
      low_q <= num[QW-1:0];
    end else if (busy_q) begin
      rem_q <= fits ? REM_W'(trial - (REM_W + 1)'(den_q)) : REM_W'(trial);
      low_q <= {low_q[QW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = low_q;

endmodule

FILE: src/dual_band_bass_exciter.sv
`timescale 1ns / 1ps
// Dual band bass exciter top level: config registers, sequencer, per channel state rings.
// Depends on dbbe_pkg, dbbe_mac and dbbe_div.
//
// Usage:
//  s_axis carries one frame: CHANNELS signed samples in tdata, channel 0 lowest.
//  m_axis returns the processed frame in the same layout, one result per frame.
//  cfg writes register cfg_index_i with cfg_data_i; cfg_ready_o is high only while idle.
//  Each channel passes through band 1 and, only when enabled, band 2. The soft
//  clip divider, one quotient bit per cycle, and the single shared multiply-
//  accumulate unit, used twelve times per band, set the processing time of a frame.
//  s_axis_tready is high only while idle; a finished frame sits in the output
//  register while the next frame is accepted. If the receiver stalls, the next
//  frame completes and then holds until the output register is free.
//  Reset clears all filter histories and DC levels, sets coefficients to zero,
//  drive to one, mix to zero and disables band 2.
module dual_band_bass_exciter #(
  parameter int SAMPLE_WIDTH = dbbe_pkg::SAMPLE_WIDTH_DEF,
  parameter int CHANNELS     = dbbe_pkg::CHANNELS_DEF,
  localparam int TDATA_W     = ((CHANNELS * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [TDATA_W-1:0]             s_axis_tdata,  // ch0 sample, ch1 sample, ..., zero pad
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [TDATA_W-1:0]             m_axis_tdata,  // ch0 sample, ch1 sample, ..., zero pad
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dbbe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dbbe_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import dbbe_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [OACC_W-1:0] OUT_HI = (OACC_W'(1) <<< (SW - 1)) - 1;
  localparam logic signed [OACC_W-1:0] OUT_LO = -(OACC_W'(1) <<< (SW - 1));

  typedef enum logic [4:0] {
    S_IDLE, S_CH_BEGIN, S_LP, S_LP_OUT, S_DRV, S_H, S_D, S_DC, S_DC_UPD,
    S_DIV, S_BP, S_BP_OUT, S_MIX, S_MIX_ACC, S_CH_END, S_DONE, S_WAIT
  } st_e;

  st_e  state_q, ret_q;
  logic [2:0]     step_q;
  logic [CW-1:0]  ch_q;
  logic           band_q;

  logic [1:0][CFG_DAT_W-1:0] lp_coef_q, bp_coef_q;
  logic [1:0][GAIN_W-1:0]    gain_q;
  logic                      b2_en_q;

  logic signed [SW-1:0] in_q  [CHANNELS];
  logic signed [SW-1:0] res_q [CHANNELS];
  logic signed [SW-1:0] out_q [CHANNELS];
  logic                 out_vld_q;

  slot_t ring_q [2][CHANNELS];

  logic signed [SIG_W-1:0]  y_q, h_q, d_q, s_q;
  logic signed [OACC_W-1:0] oacc_q;

  // mac / divider hookup
  mac_op_t                   mop;
  logic signed [MUL_A_W-1:0] ma;
  logic signed [MUL_B_W-1:0] mb;
  logic signed [ACC_W-1:0]   acc;
  logic                      div_busy;
  logic [SW-1:0]             quo;
  logic [SIG_W-1:0]          d_mag;

  slot_t                    head;
  logic [CFG_DAT_W-1:0]     lpc, bpc;
  logic [GAIN_W-1:0]        gain;
  logic signed [COEF_W-1:0] lb0, la1, la2, bb0, ba1, ba2;
  logic signed [SIG_W-1:0]  xsig;
  logic signed [MUL_A_W-1:0] y_mag;

  assign head = ring_q[band_q][0];
  assign lpc  = lp_coef_q[band_q];
  assign bpc  = bp_coef_q[band_q];
  assign gain = gain_q[band_q];
  assign lb0  = lpc[19:0];
  assign la1  = lpc[39:20];
  assign la2  = lpc[59:40];
  assign bb0  = bpc[19:0];
  assign ba1  = bpc[39:20];
  assign ba2  = bpc[59:40];
  assign xsig = SIG_W'(in_q[ch_q]);
  assign y_mag = y_q[SIG_W-1] ? -MUL_A_W'(y_q) : MUL_A_W'(y_q);
  assign d_mag = d_q[SIG_W-1] ? SIG_W'(-d_q) : SIG_W'(d_q);

  always_comb begin
    mop = '0;
    ma  = '0;
    mb  = '0;
    case (state_q)
      S_LP: begin
        mop.vld = 1'b1;
        case (step_q)
          3'd0: begin ma = MUL_A_W'(xsig); mb = MUL_B_W'(lb0); mop.clr = 1'b1; end
          3'd1: begin ma = MUL_A_W'($signed(head.lp[0])); mb = MUL_B_W'(lb0); mop.dbl = 1'b1; end
          3'd2: begin ma = MUL_A_W'($signed(head.lp[1])); mb = MUL_B_W'(lb0); end
          3'd3: begin ma = MUL_A_W'($signed(head.lp[2])); mb = MUL_B_W'(la1); mop.neg = 1'b1; end
          default: begin
            ma = MUL_A_W'($signed(head.lp[3])); mb = MUL_B_W'(la2); mop.neg = 1'b1;
          end
        endcase
      end
      S_BP: begin
        mop.vld = 1'b1;
        case (step_q)
          3'd0: begin ma = MUL_A_W'(s_q); mb = MUL_B_W'(bb0); mop.clr = 1'b1; end
          3'd1: begin ma = MUL_A_W'($signed(head.bp[1])); mb = MUL_B_W'(bb0); mop.neg = 1'b1; end
          3'd2: begin ma = MUL_A_W'($signed(head.bp[2])); mb = MUL_B_W'(ba1); mop.neg = 1'b1; end
          default: begin
            ma = MUL_A_W'($signed(head.bp[3])); mb = MUL_B_W'(ba2); mop.neg = 1'b1;
          end
        endcase
      end
      S_DRV: begin
        mop.vld = 1'b1; mop.clr = 1'b1;
        ma = y_mag;
        mb = MUL_B_W'({1'b0, gain[15:0]});
      end
      S_DC: begin
        mop.vld = 1'b1; mop.clr = 1'b1;
        ma = MUL_A_W'(d_q);
        mb = DC_RATE;
      end
      S_MIX: begin
        mop.vld = 1'b1; mop.clr = 1'b1;
        ma = MUL_A_W'(y_q);
        mb = MUL_B_W'({1'b0, gain[31:16]});
      end
      default: begin
        mop = '0;
      end
    endcase
  end

  dbbe_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mop),
    .a_i    (ma),
    .b_i    (mb),
    .acc_o  (acc)
  );

  dbbe_div #(.QW(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DC),
    .mag_i   (d_mag),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_coef_q <= '0;
      bp_coef_q <= '0;
      gain_q    <= {GAIN_RESET, GAIN_RESET};
      b2_en_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_B1_LP:   lp_coef_q[0] <= cfg_data_i;
        REG_B1_BP:   bp_coef_q[0] <= cfg_data_i;
        REG_B1_GAIN: gain_q[0]    <= cfg_data_i[GAIN_W-1:0];
        REG_B2_LP:   lp_coef_q[1] <= cfg_data_i;
        REG_B2_BP:   bp_coef_q[1] <= cfg_data_i;
        REG_B2_GAIN: gain_q[1]    <= cfg_data_i[GAIN_W-1:0];
        REG_B2_EN:   b2_en_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // accept register writes only between frames
  assign cfg_ready_o = (state_q == S_IDLE);

  // sequencer with its working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      step_q    <= '0;
      ch_q      <= '0;
      band_q    <= 1'b0;
      out_vld_q <= 1'b0;
      for (int b = 0; b < 2; b++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          ring_q[b][c] <= '0;
        end
      end
    end else begin
      if (out_vld_q && m_axis_tready && state_q != S_DONE) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            for (int c = 0; c < CHANNELS; c++) begin
              in_q[c] <= s_axis_tdata[c*SW +: SW];
            end
            ch_q    <= '0;
            state_q <= S_CH_BEGIN;
          end
        end
        S_CH_BEGIN: begin
          oacc_q  <= OACC_W'(xsig);
          band_q  <= 1'b0;
          step_q  <= '0;
          state_q <= S_LP;
        end
        S_LP: begin
          if (step_q == 3'd4) begin
            ret_q   <= S_LP_OUT;
            state_q <= S_WAIT;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_LP_OUT: begin
          y_q <= sat32((acc + (ACC_W'(1) <<< 17)) >>> 18);
          ring_q[band_q][0].lp[1] <= head.lp[0];
          ring_q[band_q][0].lp[0] <= xsig;
          ring_q[band_q][0].lp[3] <= head.lp[2];
          ring_q[band_q][0].lp[2] <= sat32((acc + (ACC_W'(1) <<< 17)) >>> 18);
          state_q <= S_DRV;
        end
        S_DRV: begin
          ret_q   <= S_H;
          state_q <= S_WAIT;
        end
        S_H: begin
          h_q     <= sat32((acc + (ACC_W'(1) <<< 10)) >>> 11);
          state_q <= S_D;
        end
        S_D: begin
          d_q     <= sat32(ACC_W'(h_q) - ACC_W'($signed(head.dc)));
          state_q <= S_DC;
        end
        S_DC: begin
          ret_q   <= S_DC_UPD;
          state_q <= S_WAIT;
        end
        S_DC_UPD: begin
          ring_q[band_q][0].dc <=
            sat32(ACC_W'($signed(head.dc)) + ((acc + (ACC_W'(1) <<< 31)) >>> 32));
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy) begin
            s_q     <= d_q[SIG_W-1] ? -SIG_W'(quo) : SIG_W'(quo);
            step_q  <= '0;
            state_q <= S_BP;
          end
        end
        S_BP: begin
          if (step_q == 3'd3) begin
            ret_q   <= S_BP_OUT;
            state_q <= S_WAIT;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_BP_OUT: begin
          y_q <= sat32((acc + (ACC_W'(1) <<< 17)) >>> 18);
          ring_q[band_q][0].bp[1] <= head.bp[0];
          ring_q[band_q][0].bp[0] <= s_q;
          ring_q[band_q][0].bp[3] <= head.bp[2];
          ring_q[band_q][0].bp[2] <= sat32((acc + (ACC_W'(1) <<< 17)) >>> 18);
          state_q <= S_MIX;
        end
        S_MIX: begin
          ret_q   <= S_MIX_ACC;
          state_q <= S_WAIT;
        end
        S_MIX_ACC: begin
          oacc_q <= oacc_q + OACC_W'((acc + (ACC_W'(1) <<< 13)) >>> 14);
          if (!band_q && b2_en_q) begin
            band_q  <= 1'b1;
            step_q  <= '0;
            state_q <= S_LP;
          end else begin
            state_q <= S_CH_END;
          end
        end
        S_CH_END: begin
          if (oacc_q > OUT_HI) begin
            res_q[ch_q] <= OUT_HI[SW-1:0];
          end else if (oacc_q < OUT_LO) begin
            res_q[ch_q] <= OUT_LO[SW-1:0];
          end else begin
            res_q[ch_q] <= oacc_q[SW-1:0];
          end
          // advance both rings so the next channel sits at the head
          for (int b = 0; b < 2; b++) begin
            for (int c = 0; c < CHANNELS - 1; c++) begin
              ring_q[b][c] <= ring_q[b][c+1];
            end
            ring_q[b][CHANNELS-1] <= ring_q[b][0];
          end
          if (ch_q == CW'(CHANNELS - 1)) begin
            state_q <= S_DONE;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= S_CH_BEGIN;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_vld_q || m_axis_tready) begin
            for (int c = 0; c < CHANNELS; c++) begin
              out_q[c] <= res_q[c];
            end
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        S_WAIT: begin
          state_q <= ret_q;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      m_axis_tdata[c*SW +: SW] = out_q[c];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;

endmodule

FILE: src/dbbe_checker.sv
`timescale 1ns / 1ps
// Port level checks of the dual band bass exciter, bound to the top level.
// Depends on dbbe_pkg.
module dbbe_checker #(
  parameter int SAMPLE_WIDTH = dbbe_pkg::SAMPLE_WIDTH_DEF,
  parameter int CHANNELS     = dbbe_pkg::CHANNELS_DEF,
  localparam int TDATA_W     = ((CHANNELS * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [TDATA_W-1:0]             s_axis_tdata,  // ch0 sample, ch1 sample, ..., zero pad
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [TDATA_W-1:0]             m_axis_tdata,  // ch0 sample, ch1 sample, ..., zero pad
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [dbbe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [dbbe_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import dbbe_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready while a frame is in work");

  a_result_frees_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result issued but sequencer not idle");

endmodule

bind dual_band_bass_exciter dbbe_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH),
  .CHANNELS     (CHANNELS)
) u_dbbe_checker (.*);

FILE: tb/dual_band_bass_exciter_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the dual band bass exciter: watches the stream and config channels,
// predicts each output frame from its own copy of registers and state, and compares.
// Depends on dbbe_pkg.
module dual_band_bass_exciter_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,  // left, right
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [47:0]                    m_axis_tdata,  // left, right
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o,
  input  logic [dbbe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dbbe_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output int unsigned                    fails_o
);
  import dbbe_pkg::*;

  localparam int COEF_FRAC = 18;
  localparam longint OUT_HI = 64'sd8388607;
  localparam longint OUT_LO = -64'sd8388608;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } stereo_t;

  logic [CFG_DAT_W-1:0] regs [7];
  // [band][bandpass][channel][x1, x2, y1, y2]
  longint filt_hist [2][2][2][4];
  longint dc_level [2][2];
  stereo_t expected_frames [$];
  int unsigned mismatches = 0;

  assign fails_o = mismatches;

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint coef_field(logic [CFG_DAT_W-1:0] r, int k);
    logic signed [19:0] f;
    f = r[20*k +: 20];
    return longint'(f);
  endfunction

  function automatic longint run_biquad(int band, int bp, int ch, longint x);
    logic [CFG_DAT_W-1:0] r;
    longint b0, b1, b2, a1, a2, acc, y;
    r = regs[band*3 + bp];
    b0 = coef_field(r, 0);
    a1 = coef_field(r, 1);
    a2 = coef_field(r, 2);
    b1 = bp ? 0 : 2 * b0;
    b2 = bp ? -b0 : b0;
    acc = b0 * x + b1 * filt_hist[band][bp][ch][0] + b2 * filt_hist[band][bp][ch][1]
          - a1 * filt_hist[band][bp][ch][2] - a2 * filt_hist[band][bp][ch][3];
    y = clamp32(round_shift(acc, COEF_FRAC));
    filt_hist[band][bp][ch][1] = filt_hist[band][bp][ch][0];
    filt_hist[band][bp][ch][0] = x;
    filt_hist[band][bp][ch][3] = filt_hist[band][bp][ch][2];
    filt_hist[band][bp][ch][2] = y;
    return y;
  endfunction

  // d / (1 + |d|), rounded half away from zero
  function automatic longint soft_clip(longint d);
    longint unsigned mag, den, q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    den = (64'd1 << 23) + mag;
    q = ((mag << 23) + den / 2) / den;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint harmonic_term(int band, int ch, longint x);
    logic [31:0] g;
    longint drive, mix, sub, mag, h, d, harm;
    g = regs[band*3 + 2][31:0];
    drive = longint'(g[15:0]);
    mix = longint'(g[31:16]);
    sub = run_biquad(band, 0, ch, x);
    mag = (sub < 0) ? -sub : sub;
    h = clamp32(round_shift(mag * drive, 11));
    d = clamp32(h - dc_level[band][ch]);
    dc_level[band][ch] = clamp32(dc_level[band][ch]
                                 + round_shift(d * longint'(DC_RATE), 32));
    harm = run_biquad(band, 1, ch, soft_clip(d));
    return round_shift(harm * mix, 14);
  endfunction

  function automatic logic signed [23:0] excite_sample(int ch, logic signed [23:0] s);
    longint x, acc;
    x = longint'(s);
    acc = x + harmonic_term(0, ch, x);
    if (regs[REG_B2_EN][0]) acc += harmonic_term(1, ch, x);
    if (acc > OUT_HI) acc = OUT_HI;
    if (acc < OUT_LO) acc = OUT_LO;
    return acc[23:0];
  endfunction

  task automatic report(string field, logic signed [23:0] got, logic signed [23:0] want);
    $display("%0t: %s got %0d, want %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stereo_t f;
    if (!rst_ni) begin
      foreach (regs[i]) regs[i] = '0;
      regs[REG_B1_GAIN] = GAIN_RESET;
      regs[REG_B2_GAIN] = GAIN_RESET;
      foreach (filt_hist[a, b, c, k]) filt_hist[a][b][c][k] = 0;
      foreach (dc_level[a, c]) dc_level[a][c] = 0;
      expected_frames.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_B1_LP, REG_B1_BP, REG_B2_LP, REG_B2_BP: begin
            regs[cfg_index_i] = cfg_data_i;
          end
          REG_B1_GAIN, REG_B2_GAIN: begin
            regs[cfg_index_i] = {28'd0, cfg_data_i[31:0]};
          end
          REG_B2_EN: begin
            regs[cfg_index_i] = {59'd0, cfg_data_i[0]};
          end
          default: ;  // drop writes past the register list
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        f.left = excite_sample(0, s_axis_tdata[23:0]);
        f.right = excite_sample(1, s_axis_tdata[47:24]);
        expected_frames.push_back(f);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: output frame with nothing pending", $realtime);
          mismatches++;
        end else begin
          f = expected_frames.pop_front();
          if (m_axis_tdata[23:0] !== f.left) report("left_out", m_axis_tdata[23:0], f.left);
          if (m_axis_tdata[47:24] !== f.right)
            report("right_out", m_axis_tdata[47:24], f.right);
        end
      end
    end
  end

endmodule

FILE: tb/dual_band_bass_exciter_test.sv
`timescale 1ns / 1ps
// Top of the dual band bass exciter testbench: clock, reset, stimulus and verdict.
// Depends on dbbe_pkg, dual_band_bass_exciter and dual_band_bass_exciter_checker.
module dual_band_bass_exciter_test;
  import dbbe_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE = 400;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // left, right
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // left, right
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  int unsigned fails;
  int unsigned frames_sent = 0;
  int unsigned frames_back = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit no_idle = 1'b0;
  logic signed [23:0] walk_l = '0;
  logic signed [23:0] walk_r = '0;

  always #6 clk_i = ~clk_i;

  dual_band_bass_exciter i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  dual_band_bass_exciter_checker i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fails_o(fails)
  );

  // receiver backpressure in bursts
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) frames_back <= frames_back + 1;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [59:0] pack_coefs(int b0, int a1, int a2);
    logic [19:0] f0, f1, f2;
    f0 = b0[19:0];
    f1 = a1[19:0];
    f2 = a2[19:0];
    return {f2, f1, f0};
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_frame(logic [23:0] left, logic [23:0] right);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {right, left};
    do @(posedge clk_i); while (!s_axis_tready);
    frames_sent++;
  endtask

  // hold until every frame is back and the block has gone idle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (frames_back != frames_sent) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [23:0] next_sample(ref logic signed [23:0] walk);
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 2) return 24'($urandom());
    if (kind <= 6) begin
      // slow bass-like wander: steady, well formed content
      walk = 24'(walk + $signed($urandom_range(0, 200000)) - 100000);
      return walk;
    end
    if (kind == 7) return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    return 24'($signed($urandom_range(0, 4096)) - 2048);
  endfunction

  task automatic random_frames(int n);
    logic [23:0] l, r;
    repeat (n) begin
      l = next_sample(walk_l);
      r = next_sample(walk_r);
      send_frame(l, r);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: pass-through
    send_frame(24'h000000, 24'h000000);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'hFFFFFF, 24'h000001);
    send_frame(24'h555555, 24'hAAAAAA);
    drain();

    // band 1 only, moderate filters
    write_reg(REG_B1_LP, pack_coefs(1442, -466125, 209715));
    write_reg(REG_B1_BP, pack_coefs(26214, -419430, 209715));
    write_reg(REG_B1_GAIN, CFG_DAT_W'({16'd16384, 16'd8192}));
    repeat (6) send_frame(24'h7FFFFF, 24'h800000);
    repeat (4) send_frame(24'h000000, 24'h000000);
    send_frame(24'h400000, 24'hC00000);
    send_frame(24'h000001, 24'hFFFFFF);
    random_frames(330);
    drain();

    // both bands
    write_reg(REG_B2_LP, pack_coefs(6000, -400000, 170000));
    write_reg(REG_B2_BP, pack_coefs(40000, -300000, 180000));
    write_reg(REG_B2_GAIN, CFG_DAT_W'({16'd32767, 16'd40000}));
    write_reg(REG_B2_EN, 60'd1);
    repeat (4) send_frame(24'h7FFFFF, 24'h7FFFFF);
    random_frames(340);
    drain();

    // extremes: full-scale gains, extreme and unstable coefficients
    write_reg(REG_B1_LP, {60{1'b1}});
    write_reg(REG_B1_BP, pack_coefs(-524288, 524287, -524288));
    write_reg(REG_B1_GAIN, CFG_DAT_W'(32'hFFFFFFFF));
    write_reg(REG_B2_LP, pack_coefs(524287, -524288, 524287));
    write_reg(REG_B2_BP, CFG_DAT_W'({$urandom(), $urandom()}));
    write_reg(REG_B2_GAIN, CFG_DAT_W'(32'hFFFF0001));
    write_reg(REG_NONE, {60{1'b1}});
    repeat (3) send_frame(24'h800000, 24'h7FFFFF);
    random_frames(330);
    drain();

    // random settings, band 2 off so its state must hold
    write_reg(REG_B1_LP, CFG_DAT_W'({$urandom(), $urandom()}));
    write_reg(REG_B1_BP, CFG_DAT_W'({$urandom(), $urandom()}));
    write_reg(REG_B1_GAIN, CFG_DAT_W'($urandom()));
    write_reg(REG_B2_EN, 60'd0);
    random_frames(340);
    drain();

    // band 2 back on with original band 1 filters, zero drive, no idling
    write_reg(REG_B1_LP, pack_coefs(1442, -466125, 209715));
    write_reg(REG_B1_BP, pack_coefs(26214, -419430, 209715));
    write_reg(REG_B1_GAIN, 60'd0);
    write_reg(REG_B2_EN, CFG_DAT_W'({$urandom(), $urandom()}) | 60'd1);
    no_idle = 1'b1;
    random_frames(340);
    drain();

    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
